// ----- src/sqd_pkg.sv -----
// shared types, constants and the note to cv table for the step sequencer
package sqd_pkg;

   localparam int STEPS = 16;
   localparam int STEP_W = 4;
   localparam int KEY_W = 16;
   localparam int LEN_W = 16;
   localparam int CH_W = 3;
   localparam int NOTE_W = 7;
   localparam int NOTE_VALUES = 128;
   localparam int CV_W = 12;
   localparam int CV_MAX = 4095;
   localparam int NOTE_TOP = 119;
   localparam int COUNT_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam int DEFAULT_CHANNELS = 8;
   localparam int DEFAULT_SETTLE_READS = 5;

   localparam logic [LEN_W-1:0] RESET_STEP_LENGTH = 16'd600;
   localparam logic [KEY_W-1:0] SCAN_IDLE = 16'hffff;

   typedef enum logic [1:0] {
      MODE_SCAN  = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_STEP_LENGTH  = 2'd0,
      CSR_RUN_ENABLE   = 2'd1,
      CSR_EDIT_CHANNEL = 2'd2
   } csr_index_type;

   typedef struct packed {
      mode_type mode;
      logic [KEY_W-1:0] scan_bits;
      logic [CH_W-1:0] wr_channel;
      logic [STEP_W-1:0] wr_step;
      logic [NOTE_W-1:0] wr_note;
      logic wr_enabled;
   } req_item_type;

   typedef struct packed {
      logic advanced;
      logic [STEP_W-1:0] step_index;
      logic [CV_W-1:0] cv_first;
      logic [CV_W-1:0] cv_second;
      logic gate_first;
      logic gate_second;
      logic gate_drum;
      logic [STEPS-1:0] led_mask;
      logic [KEY_W-1:0] keys_down;
   } rsp_item_type;

   typedef logic [CV_W-1:0] cv_table_type [NOTE_VALUES];

   // floor(note * 4095 / 119), saturated, evaluated at elaboration
   function automatic cv_table_type build_cv_table();
      cv_table_type tbl;
      int v;
      for (int n = 0; n < NOTE_VALUES; n++) begin
         v = (n * CV_MAX) / NOTE_TOP;
         tbl[n] = (v > CV_MAX) ? CV_W'(CV_MAX) : CV_W'(v);
      end
      return tbl;
   endfunction

   localparam cv_table_type CV_TABLE = build_cv_table();

endpackage

// ----- src/sqd_if.sv -----
// channel interfaces for the step sequencer: request, response and csr write
interface sqd_req_if;
   logic valid;
   logic ready;
   logic [1:0] mode;
   logic [sqd_pkg::KEY_W-1:0] scan_bits;
   logic [sqd_pkg::CH_W-1:0] wr_channel;
   logic [sqd_pkg::STEP_W-1:0] wr_step;
   logic [sqd_pkg::NOTE_W-1:0] wr_note;
   logic wr_enabled;

   modport source (
      output valid, mode, scan_bits, wr_channel, wr_step, wr_note, wr_enabled,
      input ready
   );
   modport sink (
      input valid, mode, scan_bits, wr_channel, wr_step, wr_note, wr_enabled,
      output ready
   );
endinterface

interface sqd_rsp_if;
   logic valid;
   logic ready;
   logic advanced;
   logic [sqd_pkg::STEP_W-1:0] step_index;
   logic [sqd_pkg::CV_W-1:0] cv_first;
   logic [sqd_pkg::CV_W-1:0] cv_second;
   logic gate_first;
   logic gate_second;
   logic gate_drum;
   logic [sqd_pkg::STEPS-1:0] led_mask;
   logic [sqd_pkg::KEY_W-1:0] keys_down;

   modport source (
      output valid, advanced, step_index, cv_first, cv_second, gate_first,
         gate_second, gate_drum, led_mask, keys_down,
      input ready
   );
   modport sink (
      input valid, advanced, step_index, cv_first, cv_second, gate_first,
         gate_second, gate_drum, led_mask, keys_down,
      output ready
   );
endinterface

interface sqd_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [sqd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/sqd_input_stage.sv -----
// input register: holds one accepted request until the core takes it
module sqd_input_stage (
   input  logic clock,
   input  logic reset,
   sqd_req_if.sink req_chan,
   input  logic take,
   output logic item_valid,
   output sqd_pkg::req_item_type item
);

   logic valid_ff, valid_in;
   sqd_pkg::req_item_type item_ff, item_in;
   logic accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = accept ? 1'b1 : (take ? 1'b0 : valid_ff);
      item_in = item_ff;
      if (accept) begin
         item_in.mode = sqd_pkg::mode_type'(req_chan.mode);
         item_in.scan_bits = req_chan.scan_bits;
         item_in.wr_channel = req_chan.wr_channel;
         item_in.wr_step = req_chan.wr_step;
         item_in.wr_note = req_chan.wr_note;
         item_in.wr_enabled = req_chan.wr_enabled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// ----- src/sqd_core.sv -----
// sequencer state, config registers and the single-pass update logic
module sqd_core #(
   parameter int CHANNELS = sqd_pkg::DEFAULT_CHANNELS,
   parameter int SETTLE_READS = sqd_pkg::DEFAULT_SETTLE_READS
) (
   input  logic clock,
   input  logic reset,
   sqd_csr_if.sink csr_chan,
   input  logic item_valid,
   input  sqd_pkg::req_item_type item,
   input  logic out_free,
   output logic take,
   output sqd_pkg::rsp_item_type result
);

   localparam int ROW_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [sqd_pkg::COUNT_W-1:0] SETTLE_COUNT = sqd_pkg::COUNT_W'(SETTLE_READS);

   // config
   logic [sqd_pkg::LEN_W-1:0] step_length_ff;
   logic run_enable_ff;
   logic [sqd_pkg::CH_W-1:0] edit_channel_ff;

   // state
   logic [sqd_pkg::STEPS-1:0] rows_ff [CHANNELS];
   logic [sqd_pkg::STEPS-1:0] rows_in [CHANNELS];
   // only channels 0 and 1 notes reach an output
   logic [sqd_pkg::NOTE_W-1:0] notes0_ff [sqd_pkg::STEPS];
   logic [sqd_pkg::NOTE_W-1:0] notes0_in [sqd_pkg::STEPS];
   logic [sqd_pkg::NOTE_W-1:0] notes1_ff [sqd_pkg::STEPS];
   logic [sqd_pkg::NOTE_W-1:0] notes1_in [sqd_pkg::STEPS];
   logic [sqd_pkg::STEP_W-1:0] step_ff, step_in;
   logic [sqd_pkg::LEN_W-1:0] elapsed_ff, elapsed_in;
   logic [sqd_pkg::KEY_W-1:0] last_scan_ff, last_scan_in;
   logic [sqd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [sqd_pkg::KEY_W-1:0] settled_ff, settled_in;

   logic edit_ok, wr_ok, advanced;
   logic [ROW_W-1:0] edit_sel, wr_sel;
   logic [sqd_pkg::STEPS-1:0] edit_row;

   assign take = item_valid && out_free;
   assign csr_chan.ready = 1'b1;

   assign edit_ok = (32'(edit_channel_ff) < CHANNELS);
   assign wr_ok = (32'(item.wr_channel) < CHANNELS);
   assign edit_sel = ROW_W'(32'(edit_channel_ff));
   assign wr_sel = ROW_W'(32'(item.wr_channel));

   always_comb begin
      rows_in = rows_ff;
      notes0_in = notes0_ff;
      notes1_in = notes1_ff;
      step_in = step_ff;
      elapsed_in = elapsed_ff;
      last_scan_in = last_scan_ff;
      count_in = count_ff;
      settled_in = settled_ff;
      advanced = 1'b0;
      if (take) begin
         case (item.mode)
            sqd_pkg::MODE_SCAN: begin
               if (item.scan_bits == last_scan_ff) begin
                  count_in = count_ff + 1'b1;
                  if (count_in == SETTLE_COUNT) begin
                     if (edit_ok) begin
                        rows_in[edit_sel] = rows_ff[edit_sel] ^ (settled_ff & item.scan_bits);
                     end
                     settled_in = ~item.scan_bits;
                  end
               end else begin
                  last_scan_in = item.scan_bits;
                  count_in = '0;
               end
            end
            sqd_pkg::MODE_TICK: begin
               elapsed_in = elapsed_ff + 1'b1;
            end
            sqd_pkg::MODE_WRITE: begin
               if (wr_ok) begin
                  rows_in[wr_sel][item.wr_step] = item.wr_enabled;
                  if (item.wr_channel == sqd_pkg::CH_W'(0)) begin
                     notes0_in[item.wr_step] = item.wr_note;
                  end
                  if (item.wr_channel == sqd_pkg::CH_W'(1)) begin
                     notes1_in[item.wr_step] = item.wr_note;
                  end
               end
            end
            default: begin
            end
         endcase
         if (run_enable_ff && (elapsed_in > step_length_ff)) begin
            step_in = step_ff + 1'b1;
            elapsed_in = elapsed_in - step_length_ff;
            advanced = 1'b1;
         end
      end
   end

   always_comb begin
      edit_row = edit_ok ? rows_in[edit_sel] : '0;
      result.advanced = advanced;
      result.step_index = step_in;
      result.cv_first = sqd_pkg::CV_TABLE[notes0_in[step_in]];
      result.cv_second = sqd_pkg::CV_TABLE[notes1_in[step_in]];
      result.gate_first = rows_in[0][step_in];
      result.gate_second = rows_in[1][step_in];
      result.gate_drum = step_in[0];
      result.led_mask = edit_row ^ (sqd_pkg::STEPS'(1) << step_in);
      result.keys_down = settled_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_length_ff <= sqd_pkg::RESET_STEP_LENGTH;
         run_enable_ff <= 1'b1;
         edit_channel_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            rows_ff[c] <= '0;
         end
         for (int s = 0; s < sqd_pkg::STEPS; s++) begin
            notes0_ff[s] <= '0;
            notes1_ff[s] <= '0;
         end
         step_ff <= '0;
         elapsed_ff <= '0;
         last_scan_ff <= sqd_pkg::SCAN_IDLE;
         count_ff <= '0;
         settled_ff <= '0;
      end else begin
         if (csr_chan.valid) begin
            case (sqd_pkg::csr_index_type'(csr_chan.index))
               sqd_pkg::CSR_STEP_LENGTH: step_length_ff <= csr_chan.data[sqd_pkg::LEN_W-1:0];
               sqd_pkg::CSR_RUN_ENABLE: run_enable_ff <= csr_chan.data[0];
               sqd_pkg::CSR_EDIT_CHANNEL: edit_channel_ff <= csr_chan.data[sqd_pkg::CH_W-1:0];
               default: begin
               end
            endcase
         end
         rows_ff <= rows_in;
         notes0_ff <= notes0_in;
         notes1_ff <= notes1_in;
         step_ff <= step_in;
         elapsed_ff <= elapsed_in;
         last_scan_ff <= last_scan_in;
         count_ff <= count_in;
         settled_ff <= settled_in;
      end
   end

endmodule

// ----- src/sqd_output_stage.sv -----
// result register: holds one response until the sink takes it
module sqd_output_stage (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  sqd_pkg::rsp_item_type result,
   output logic out_free,
   sqd_rsp_if.source rsp_chan
);

   logic valid_ff, valid_in;
   sqd_pkg::rsp_item_type rsp_ff, rsp_in;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);
      rsp_in = load ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.advanced = rsp_ff.advanced;
   assign rsp_chan.step_index = rsp_ff.step_index;
   assign rsp_chan.cv_first = rsp_ff.cv_first;
   assign rsp_chan.cv_second = rsp_ff.cv_second;
   assign rsp_chan.gate_first = rsp_ff.gate_first;
   assign rsp_chan.gate_second = rsp_ff.gate_second;
   assign rsp_chan.gate_drum = rsp_ff.gate_drum;
   assign rsp_chan.led_mask = rsp_ff.led_mask;
   assign rsp_chan.keys_down = rsp_ff.keys_down;

endmodule

// ----- src/step_sequencer_with_key_debounce_top.sv -----
// step sequencer top level: input register, update logic, result register
//
// Takes one request per clock and returns exactly one response for each; a request passes
// through the input register and then the result register on its way to a response.
// The state update for a request and its response are formed in the same cycle by
// short logic between those two registers, so back-to-back requests run at one per
// clock; the rate drops only while the response sink holds ready low. A key scan is
// settled after it repeats until its count reaches SETTLE_READS, and a settled release
// toggles that step in the edited channel. Config writes are taken every cycle and
// should only be issued while no request is in flight.
module step_sequencer_with_key_debounce_top #(
   parameter int CHANNELS = sqd_pkg::DEFAULT_CHANNELS,
   parameter int SETTLE_READS = sqd_pkg::DEFAULT_SETTLE_READS
) (
   input  logic clock,
   input  logic reset,
   sqd_req_if.sink req_chan,
   sqd_rsp_if.source rsp_chan,
   sqd_csr_if.sink csr_chan
);

   logic item_valid, take, out_free;
   sqd_pkg::req_item_type item;
   sqd_pkg::rsp_item_type result;

   sqd_input_stage u_input (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .take(take),
      .item_valid(item_valid),
      .item(item)
   );

   sqd_core #(
      .CHANNELS(CHANNELS),
      .SETTLE_READS(SETTLE_READS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .csr_chan(csr_chan),
      .item_valid(item_valid),
      .item(item),
      .out_free(out_free),
      .take(take),
      .result(result)
   );

   sqd_output_stage u_output (
      .clock(clock),
      .reset(reset),
      .load(take),
      .result(result),
      .out_free(out_free),
      .rsp_chan(rsp_chan)
   );

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

   // requests stall only behind a stalled response
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("request stalled without a response stall");

   // drum gate tracks step parity
   a_drum_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.gate_drum == rsp_chan.step_index[0]))
      else $error("drum gate does not match step parity");

   // a transfer into the result register always follows a held item
   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_chan.valid)
      else $error("result register empty after a transfer");

endmodule

// ----- tb/step_sequencer_with_key_debounce_top_tb.sv -----
// testbench for the step sequencer: directed and random traffic checked against a local model
module step_sequencer_with_key_debounce_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS = sqd_pkg::DEFAULT_CHANNELS;
   localparam int SETTLE_READS = sqd_pkg::DEFAULT_SETTLE_READS;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int PHASES = 13;
   localparam int PHASE_ITEMS = 120;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset;

   sqd_req_if req_bus();
   sqd_rsp_if rsp_bus();
   sqd_csr_if csr_bus();

   step_sequencer_with_key_debounce_top #(
      .CHANNELS(CHANNELS),
      .SETTLE_READS(SETTLE_READS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   logic [sqd_pkg::STEPS-1:0] enable_rows [CHANNELS];
   logic [sqd_pkg::NOTE_W-1:0] note_store [CHANNELS*sqd_pkg::STEPS];
   logic [sqd_pkg::STEP_W-1:0] step_pos;
   logic [sqd_pkg::LEN_W-1:0] elapsed_ms;
   logic [sqd_pkg::KEY_W-1:0] last_scan;
   logic [sqd_pkg::COUNT_W-1:0] repeat_count;
   logic [sqd_pkg::KEY_W-1:0] settled_keys;
   logic [sqd_pkg::LEN_W-1:0] cfg_step_length;
   logic cfg_run;
   logic [sqd_pkg::CH_W-1:0] cfg_edit;

   sqd_pkg::rsp_item_type expected_outputs[$];
   int mismatches;
   int cycle_count;
   bit calm;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [sqd_pkg::CV_W-1:0] cv_of_note(
      input logic [sqd_pkg::NOTE_W-1:0] note);
      int v;
      v = int'(note) * sqd_pkg::CV_MAX / sqd_pkg::NOTE_TOP;
      return (v > sqd_pkg::CV_MAX) ? sqd_pkg::CV_W'(sqd_pkg::CV_MAX) : sqd_pkg::CV_W'(v);
   endfunction

   function automatic void clear_sequencer_state();
      for (int c = 0; c < CHANNELS; c++) enable_rows[c] = '0;
      for (int n = 0; n < CHANNELS*sqd_pkg::STEPS; n++) note_store[n] = '0;
      step_pos = '0;
      elapsed_ms = '0;
      last_scan = sqd_pkg::SCAN_IDLE;
      repeat_count = '0;
      settled_keys = '0;
      cfg_step_length = sqd_pkg::RESET_STEP_LENGTH;
      cfg_run = 1'b1;
      cfg_edit = '0;
   endfunction

   // updates the sequencer state for one item and returns the outputs it shows
   function automatic sqd_pkg::rsp_item_type apply_item(input sqd_pkg::req_item_type item);
      sqd_pkg::rsp_item_type r;
      logic [sqd_pkg::KEY_W-1:0] released;
      logic [sqd_pkg::STEPS-1:0] row;
      r = '0;
      case (item.mode)
         sqd_pkg::MODE_SCAN: begin
            if (item.scan_bits == last_scan) begin
               repeat_count = repeat_count + 1'b1;
               if (repeat_count == sqd_pkg::COUNT_W'(SETTLE_READS)) begin
                  released = settled_keys & item.scan_bits;
                  if (int'(cfg_edit) < CHANNELS)
                     enable_rows[cfg_edit] = enable_rows[cfg_edit] ^ released;
                  settled_keys = ~item.scan_bits;
               end
            end else begin
               last_scan = item.scan_bits;
               repeat_count = '0;
            end
         end
         sqd_pkg::MODE_TICK: elapsed_ms = elapsed_ms + 1'b1;
         sqd_pkg::MODE_WRITE: begin
            if (int'(item.wr_channel) < CHANNELS) begin
               note_store[int'(item.wr_channel)*sqd_pkg::STEPS + int'(item.wr_step)] =
                  item.wr_note;
               enable_rows[item.wr_channel][item.wr_step] = item.wr_enabled;
            end
         end
         default: ;
      endcase
      if (cfg_run && elapsed_ms > cfg_step_length) begin
         step_pos = step_pos + 1'b1;
         elapsed_ms = elapsed_ms - cfg_step_length;
         r.advanced = 1'b1;
      end
      row = (int'(cfg_edit) < CHANNELS) ? enable_rows[cfg_edit] : '0;
      r.step_index = step_pos;
      r.cv_first = cv_of_note(note_store[int'(step_pos)]);
      r.cv_second = cv_of_note(note_store[sqd_pkg::STEPS + int'(step_pos)]);
      r.gate_first = enable_rows[0][step_pos];
      r.gate_second = enable_rows[1][step_pos];
      r.gate_drum = step_pos[0];
      r.led_mask = row ^ (sqd_pkg::STEPS'(1) << step_pos);
      r.keys_down = settled_keys;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      sqd_pkg::rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_outputs.size() == 0) begin
            $error("response transfer with no item outstanding");
            mismatches++;
         end else begin
            want = expected_outputs.pop_front();
            check_field("advanced", 16'(want.advanced), 16'(rsp_bus.advanced));
            check_field("step_index", 16'(want.step_index), 16'(rsp_bus.step_index));
            check_field("cv_first", 16'(want.cv_first), 16'(rsp_bus.cv_first));
            check_field("cv_second", 16'(want.cv_second), 16'(rsp_bus.cv_second));
            check_field("gate_first", 16'(want.gate_first), 16'(rsp_bus.gate_first));
            check_field("gate_second", 16'(want.gate_second), 16'(rsp_bus.gate_second));
            check_field("gate_drum", 16'(want.gate_drum), 16'(rsp_bus.gate_drum));
            check_field("led_mask", want.led_mask, rsp_bus.led_mask);
            check_field("keys_down", want.keys_down, rsp_bus.keys_down);
         end
      end
   end

   // response sink with random stalls
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   function automatic sqd_pkg::req_item_type make_item(input logic [1:0] mode_bits);
      sqd_pkg::req_item_type item;
      item.mode = sqd_pkg::mode_type'(mode_bits);
      item.scan_bits = sqd_pkg::KEY_W'($urandom);
      item.wr_channel = sqd_pkg::CH_W'($urandom);
      item.wr_step = sqd_pkg::STEP_W'($urandom);
      item.wr_note = sqd_pkg::NOTE_W'($urandom);
      item.wr_enabled = 1'($urandom);
      return item;
   endfunction

   function automatic sqd_pkg::req_item_type write_item(
      input logic [sqd_pkg::CH_W-1:0] ch,
      input logic [sqd_pkg::STEP_W-1:0] step,
      input logic [sqd_pkg::NOTE_W-1:0] note,
      input logic enabled);
      sqd_pkg::req_item_type item;
      item = make_item(sqd_pkg::MODE_WRITE);
      item.wr_channel = ch;
      item.wr_step = step;
      item.wr_note = note;
      item.wr_enabled = enabled;
      return item;
   endfunction

   // valid stays high after a transfer unless a gap follows
   task automatic send_item(input sqd_pkg::req_item_type item);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= item.mode;
      req_bus.scan_bits <= item.scan_bits;
      req_bus.wr_channel <= item.wr_channel;
      req_bus.wr_step <= item.wr_step;
      req_bus.wr_note <= item.wr_note;
      req_bus.wr_enabled <= item.wr_enabled;
      do @(posedge clock); while (!req_bus.ready);
      expected_outputs.push_back(apply_item(item));
   endtask

   task automatic send_scans(input logic [sqd_pkg::KEY_W-1:0] word, input int reps);
      sqd_pkg::req_item_type item;
      for (int i = 0; i < reps; i++) begin
         item = make_item(sqd_pkg::MODE_SCAN);
         item.scan_bits = word;
         send_item(item);
      end
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++) send_item(make_item(sqd_pkg::MODE_TICK));
   endtask

   task automatic settle_outputs();
      req_bus.valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx,
                            input logic [sqd_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         sqd_pkg::CSR_STEP_LENGTH: cfg_step_length = value;
         sqd_pkg::CSR_RUN_ENABLE: cfg_run = value[0];
         sqd_pkg::CSR_EDIT_CHANNEL: cfg_edit = value[sqd_pkg::CH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [sqd_pkg::LEN_W-1:0] step_len, input logic run,
                             input logic [sqd_pkg::CH_W-1:0] channel);
      settle_outputs();
      write_csr(CSR_UNUSED, sqd_pkg::CSR_DATA_W'($urandom));
      write_csr(sqd_pkg::CSR_STEP_LENGTH, step_len);
      write_csr(sqd_pkg::CSR_RUN_ENABLE, {15'($urandom), run});
      write_csr(sqd_pkg::CSR_EDIT_CHANNEL, {13'($urandom), channel});
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_ticks(1);
      send_item(make_item(MODE_UNUSED));
   endtask

   task automatic test_pattern_extremes();
      set_config('1, 1'b1, 3'd7);
      send_item(write_item(3'd0, 4'd0, 7'd0, 1'b1));
      send_item(write_item(3'd1, 4'd0, 7'd127, 1'b1));
      send_item(write_item(3'd0, 4'd1, 7'd119, 1'b0));
      send_item(write_item(3'd1, 4'd1, 7'd120, 1'b1));
      send_item(write_item(3'd7, 4'd15, 7'd127, 1'b1));
      send_item(write_item(3'd0, 4'd2, 7'd118, 1'b1));
   endtask

   task automatic test_key_release_toggle();
      set_config('1, 1'b1, 3'd0);
      send_scans('0, SETTLE_READS + 1);
      send_scans(sqd_pkg::SCAN_IDLE, SETTLE_READS + 1);
   endtask

   task automatic test_step_timing();
      set_config(16'd2, 1'b1, 3'd0);
      send_ticks(4);
      set_config('0, 1'b1, 3'd1);
      send_ticks(1);
      send_scans(16'h5a5a, 1);
      send_item(make_item(MODE_UNUSED));
      set_config('1, 1'b1, 3'd0);
      send_ticks(2);
      set_config(16'd1, 1'b0, 3'd0);
      send_ticks(2);
      set_config(16'd1, 1'b1, 3'd0);
      send_item(make_item(MODE_UNUSED));
   endtask

   task automatic test_random_traffic();
      logic [sqd_pkg::LEN_W-1:0] step_len;
      logic [sqd_pkg::KEY_W-1:0] word;
      int budget;
      int reps;
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 7))
            0: step_len = '0;
            1: step_len = '1;
            2: step_len = sqd_pkg::LEN_W'($urandom);
            default: step_len = sqd_pkg::LEN_W'($urandom_range(1, 12));
         endcase
         set_config(step_len, $urandom_range(0, 4) != 0, sqd_pkg::CH_W'($urandom));
         calm = ($urandom_range(0, 3) == 0);
         budget = PHASE_ITEMS;
         while (budget > 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3: word = sqd_pkg::SCAN_IDLE;
                     4, 5, 6: word = ~(sqd_pkg::KEY_W'(1)
                                       << $urandom_range(0, sqd_pkg::KEY_W-1));
                     7: word = '0;
                     default: word = sqd_pkg::KEY_W'($urandom);
                  endcase
                  reps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, SETTLE_READS)
                                                     : $urandom_range(SETTLE_READS + 1,
                                                                      SETTLE_READS + 2);
                  send_scans(word, reps);
                  budget -= reps;
               end
               4, 5, 6: begin
                  reps = $urandom_range(1, 10);
                  send_ticks(reps);
                  budget -= reps;
               end
               7, 8: begin
                  send_item(make_item(sqd_pkg::MODE_WRITE));
                  budget--;
               end
               default: begin
                  send_item(make_item(2'($urandom_range(0, 3))));
                  budget--;
               end
            endcase
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      mismatches = 0;
      cycle_count = 0;
      calm = 1'b0;
      clear_sequencer_state();
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.mode <= sqd_pkg::MODE_SCAN;
      req_bus.scan_bits <= sqd_pkg::SCAN_IDLE;
      req_bus.wr_channel <= '0;
      req_bus.wr_step <= '0;
      req_bus.wr_note <= '0;
      req_bus.wr_enabled <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= sqd_pkg::CSR_STEP_LENGTH;
      csr_bus.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_pattern_extremes();
      test_key_release_toggle();
      test_step_timing();
      test_random_traffic();

      settle_outputs();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
